// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console writer package
// Shared types and fixed constants of the text console writer: function
// codes, field widths, the cell request to the index unit and the sequencer
// states.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Fixed field widths of the stream words.
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int COL_FW = 7;
    localparam int ROW_FW = 5;
    localparam int CELL_W = 16;
    localparam int POS_W  = 11;

    // Character and cell codes.
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

    // Function selector carried in tuser.
    typedef enum logic [1:0] {
        FUNC_PUT_CHAR = 2'd0,
        FUNC_READ     = 2'd1,
        FUNC_PUT_AT   = 2'd2,
        FUNC_NOP      = 2'd3
    } t_func;

    // Request to the shared index unit.
    typedef struct packed {
        logic              load;
        logic              use_base;
        logic [ROW_FW-1:0] base;
        logic [ROW_FW-1:0] row;
        logic [COL_FW-1:0] col;
    } t_index_req;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_WRITE,
        ST_READ,
        ST_MOVE,
        ST_BLANK_START,
        ST_BLANK,
        ST_POS,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/tcw_index_unit.sv =====
// ----------------------------------------------------------------------------
// Text console index unit
// Shared address unit: maps a row and column to a linear cell index, with an
// optional ring offset on the row, and registers the result.
// ----------------------------------------------------------------------------
module tcw_index_unit
    import tcw_pkg::*;
#(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25
) (
    input  logic                                     i_clk,
    input  t_index_req                               i_req,
    output logic [$clog2(SCREEN_COLS*SCREEN_ROWS)-1:0] o_index
);

    localparam int ROW_W = $clog2(SCREEN_ROWS);
    localparam int COL_W = $clog2(SCREEN_COLS);
    localparam int IDX_W = $clog2(SCREEN_COLS * SCREEN_ROWS);

    logic [ROW_W:0]     w_sum;
    logic [ROW_W-1:0]   w_phys_row;
    logic [IDX_W-1:0]   n_index;
    logic [IDX_W-1:0]   r_index;

    // Ring offset on the row: both terms are below the row count, so one
    // compare and subtract brings the sum back into range.
    always_comb begin
        w_sum = {1'b0, i_req.row[ROW_W-1:0]};
        if (i_req.use_base) begin
            w_sum = w_sum + {1'b0, i_req.base[ROW_W-1:0]};
        end
        if (w_sum >= (ROW_W+1)'(SCREEN_ROWS)) begin
            w_sum = w_sum - (ROW_W+1)'(SCREEN_ROWS);
        end
        w_phys_row = w_sum[ROW_W-1:0];
        n_index = IDX_W'(w_phys_row) * IDX_W'(SCREEN_COLS)
                + IDX_W'(i_req.col[COL_W-1:0]);
    end

    // The index is held until the next request.
    always_ff @(posedge i_clk) begin
        if (i_req.load) begin
            r_index <= n_index;
        end
    end

    assign o_index = r_index;

endmodule

// ===== rtl/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// Text console writer
// Text screen of character and attribute cells with a put-char cursor,
// scrolling by a rotating row offset, put-at and read of single cells.
// ----------------------------------------------------------------------------
// After reset the block blanks the screen memory, one cell a cycle, and
// accepts no word until that is done; configuration writes are taken at any
// time. Each accepted word then yields one result word. Every word passes a
// decode step, a cursor position step and a final step; a read adds a read
// step, an on-screen put-at a write step, a newline a cursor move, a put-char
// a write and a cursor move, and a put-char or newline that scrolls adds the
// blanking of the new bottom row. A result still waiting at the output
// holds the next word in its final step until the receiver takes it. These
// steps come from the single shared index unit, which registers its result
// and is used for the cell address and again for the cursor position, and
// from the one write port of the screen memory. Scrolling moves no cells: a
// row offset rotates instead.
// ----------------------------------------------------------------------------
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: text attribute for put-char.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    // Command stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // char_code[7:0], cell_attr[15:8],
                                       // cell_col[22:16], cell_row[27:23], zero
    input  logic [1:0]  s_axis_tuser,  // func[1:0]
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // cell_data[15:0], cursor_pos[26:16],
                                       // scrolled[27], bad_address[28], zero
);

    localparam int ROW_W = $clog2(SCREEN_ROWS);
    localparam int COL_W = $clog2(SCREEN_COLS);
    localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
    localparam int IDX_W = $clog2(CELLS);
    localparam int FL_W  = $clog2(SCREEN_COLS);

    // Sequencer and cursor state.
    t_state              r_state, n_state;
    logic [ROW_W-1:0]    r_cursor_row, n_cursor_row;
    logic [COL_W-1:0]    r_cursor_col, n_cursor_col;
    logic [ROW_W-1:0]    r_base, n_base;
    logic [ATTR_W-1:0]   r_text_attr;

    // Latched command word.
    t_func               r_func, n_func;
    logic [CHAR_W-1:0]   r_char, n_char;
    logic [ATTR_W-1:0]   r_attr_in, n_attr_in;
    logic [COL_FW-1:0]   r_col_in, n_col_in;
    logic [ROW_FW-1:0]   r_row_in, n_row_in;

    // Step flags and sweep counters.
    logic                r_scrolled, n_scrolled;
    logic                r_bad, n_bad;
    logic [IDX_W-1:0]    r_fill_addr, n_fill_addr;
    logic [FL_W-1:0]     r_fill_left, n_fill_left;

    // Output register.
    logic                r_out_valid, n_out_valid;
    logic [CELL_W-1:0]   r_out_data, n_out_data;
    logic [POS_W-1:0]    r_out_pos, n_out_pos;
    logic                r_out_scrolled, n_out_scrolled;
    logic                r_out_bad, n_out_bad;

    // Screen memory.
    logic [CELL_W-1:0]   r_cells [CELLS];
    logic [CELL_W-1:0]   r_mem_q;
    logic                w_mem_we;
    logic [IDX_W-1:0]    w_mem_waddr;
    logic [CELL_W-1:0]   w_mem_wdata;
    logic                w_mem_re;

    // Index unit.
    t_index_req          w_req;
    logic [IDX_W-1:0]    w_index;
    logic [31:0]         w_index_ext;

    logic                w_on_screen;
    logic                w_accept;

    tcw_index_unit #(
        .SCREEN_COLS(SCREEN_COLS),
        .SCREEN_ROWS(SCREEN_ROWS)
    ) u_index (
        .i_clk  (i_clk),
        .i_req  (w_req),
        .o_index(w_index)
    );

    assign w_index_ext   = 32'(w_index);
    assign w_on_screen   = (r_col_in < COL_FW'(SCREEN_COLS))
                        && (r_row_in < ROW_FW'(SCREEN_ROWS));
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_bad, r_out_scrolled, r_out_pos, r_out_data};

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_attr <= ATTR_RESET;
        end else if (i_cfg_valid) begin
            r_text_attr <= i_cfg_data;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_cursor_row <= '0;
            r_cursor_col <= '0;
            r_base       <= '0;
            r_fill_addr  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cursor_row <= n_cursor_row;
            r_cursor_col <= n_cursor_col;
            r_base       <= n_base;
            r_fill_addr  <= n_fill_addr;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_func         <= n_func;
        r_char         <= n_char;
        r_attr_in      <= n_attr_in;
        r_col_in       <= n_col_in;
        r_row_in       <= n_row_in;
        r_scrolled     <= n_scrolled;
        r_bad          <= n_bad;
        r_fill_left    <= n_fill_left;
        r_out_data     <= n_out_data;
        r_out_pos      <= n_out_pos;
        r_out_scrolled <= n_out_scrolled;
        r_out_bad      <= n_out_bad;
    end

    // Screen memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_cells[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_mem_q <= r_cells[w_index];
        end
    end

    // Sequencer: next state, memory and index unit control.
    always_comb begin
        n_state        = r_state;
        n_cursor_row   = r_cursor_row;
        n_cursor_col   = r_cursor_col;
        n_base         = r_base;
        n_func         = r_func;
        n_char         = r_char;
        n_attr_in      = r_attr_in;
        n_col_in       = r_col_in;
        n_row_in       = r_row_in;
        n_scrolled     = r_scrolled;
        n_bad          = r_bad;
        n_fill_addr    = r_fill_addr;
        n_fill_left    = r_fill_left;
        n_out_valid    = r_out_valid && !m_axis_tready;
        n_out_data     = r_out_data;
        n_out_pos      = r_out_pos;
        n_out_scrolled = r_out_scrolled;
        n_out_bad      = r_out_bad;
        w_mem_we       = 1'b0;
        w_mem_waddr    = w_index;
        w_mem_wdata    = BLANK_CELL;
        w_mem_re       = 1'b0;
        w_req          = '0;

        case (r_state)
            // Blank every cell after reset.
            ST_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_fill_addr;
                n_fill_addr = r_fill_addr + IDX_W'(1);
                if (r_fill_addr == IDX_W'(CELLS - 1)) begin
                    n_state = ST_IDLE;
                end
            end

            // Take a command word.
            ST_IDLE: begin
                if (w_accept) begin
                    n_func    = t_func'(s_axis_tuser);
                    n_char    = s_axis_tdata[7:0];
                    n_attr_in = s_axis_tdata[15:8];
                    n_col_in  = s_axis_tdata[22:16];
                    n_row_in  = s_axis_tdata[27:23];
                    n_state   = ST_DECODE;
                end
            end

            // Start the cell address or go straight on to the cursor.
            ST_DECODE: begin
                n_scrolled = 1'b0;
                n_bad      = 1'b0;
                n_state    = ST_POS;
                case (r_func)
                    FUNC_PUT_CHAR: begin
                        if (r_char == NEWLINE_CODE) begin
                            n_state = ST_MOVE;
                        end else begin
                            w_req.load     = 1'b1;
                            w_req.use_base = 1'b1;
                            w_req.base     = ROW_FW'(r_base);
                            w_req.row      = ROW_FW'(r_cursor_row);
                            w_req.col      = COL_FW'(r_cursor_col);
                            n_state        = ST_WRITE;
                        end
                    end
                    FUNC_READ, FUNC_PUT_AT: begin
                        if (w_on_screen) begin
                            w_req.load     = 1'b1;
                            w_req.use_base = 1'b1;
                            w_req.base     = ROW_FW'(r_base);
                            w_req.row      = r_row_in;
                            w_req.col      = r_col_in;
                            n_state = (r_func == FUNC_READ) ? ST_READ : ST_WRITE;
                        end else begin
                            n_bad = 1'b1;
                        end
                    end
                    default: begin
                        n_state = ST_POS;
                    end
                endcase
            end

            // Write the cell whose index the unit now holds.
            ST_WRITE: begin
                w_mem_we = 1'b1;
                if (r_func == FUNC_PUT_CHAR) begin
                    w_mem_wdata = {r_text_attr, r_char};
                    n_state     = ST_MOVE;
                end else begin
                    w_mem_wdata = {r_attr_in, r_char};
                    n_state     = ST_POS;
                end
            end

            // Read the cell; data lands in the read register.
            ST_READ: begin
                w_mem_re = 1'b1;
                n_state  = ST_POS;
            end

            // Advance the cursor, wrapping and scrolling as needed.
            ST_MOVE: begin
                n_state = ST_POS;
                if ((r_char == NEWLINE_CODE)
                        || (r_cursor_col == COL_W'(SCREEN_COLS - 1))) begin
                    n_cursor_col = '0;
                    if (r_cursor_row == ROW_W'(SCREEN_ROWS - 1)) begin
                        // The top physical row becomes the new bottom row.
                        w_req.load = 1'b1;
                        w_req.base = '0;
                        w_req.row  = ROW_FW'(r_base);
                        w_req.col  = '0;
                        n_base     = (r_base == ROW_W'(SCREEN_ROWS - 1)) ?
                                     '0 : r_base + ROW_W'(1);
                        n_scrolled = 1'b1;
                        n_state    = ST_BLANK_START;
                    end else begin
                        n_cursor_row = r_cursor_row + ROW_W'(1);
                    end
                end else begin
                    n_cursor_col = r_cursor_col + COL_W'(1);
                end
            end

            // Load the sweep over the new bottom row.
            ST_BLANK_START: begin
                n_fill_addr = w_index;
                n_fill_left = FL_W'(SCREEN_COLS - 1);
                n_state     = ST_BLANK;
            end

            ST_BLANK: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_fill_addr;
                n_fill_addr = r_fill_addr + IDX_W'(1);
                n_fill_left = r_fill_left - FL_W'(1);
                if (r_fill_left == '0) begin
                    n_state = ST_POS;
                end
            end

            // Linear cursor position through the same unit, no row offset.
            ST_POS: begin
                w_req.load = 1'b1;
                w_req.row  = ROW_FW'(r_cursor_row);
                w_req.col  = COL_FW'(r_cursor_col);
                n_state    = ST_DONE;
            end

            // Hand the result to the output register once it is free.
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid    = 1'b1;
                    n_out_data     = (r_func == FUNC_READ && !r_bad) ? r_mem_q : '0;
                    n_out_pos      = w_index_ext[POS_W-1:0];
                    n_out_scrolled = r_scrolled;
                    n_out_bad      = r_bad;
                    n_state        = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // The cursor and the row offset always stay on the screen.
    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cursor_row < ROW_W'(SCREEN_ROWS - 1) || r_cursor_row == ROW_W'(SCREEN_ROWS - 1))
        && (r_cursor_col < COL_W'(SCREEN_COLS - 1)
            || r_cursor_col == COL_W'(SCREEN_COLS - 1)))
        else $error("cursor left the screen");

    a_base_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base < ROW_W'(SCREEN_ROWS - 1) || r_base == ROW_W'(SCREEN_ROWS - 1))
        else $error("row offset out of range");

    // The cursor sits on the last row while a scrolled result is shown, and stays there.
    a_scroll_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_scrolled) |-> (r_cursor_row == ROW_W'(SCREEN_ROWS - 1)))
        else $error("scrolled result with cursor off the last row");

    // A row blank sweep never runs past the end of the memory.
    a_blank_in_memory: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BLANK) |-> (r_fill_addr < IDX_W'(CELLS - 1)
                                   || r_fill_addr == IDX_W'(CELLS - 1)))
        else $error("blank sweep beyond the screen memory");

    // A scroll always leaves the cursor in column zero.
    a_scroll_col_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BLANK_START) |-> (r_cursor_col == '0))
        else $error("scroll without return to column zero");

endmodule
